// ===== rtl/double_hash_table_engine_top_assert.svh =====
// Assertion macros for the double hash table engine.
`ifndef DOUBLE_HASH_TABLE_ENGINE_TOP_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DHTE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dhte check failed");

// Next-cycle implication, checked out of reset.
`define DHTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dhte check failed");

`endif

// ===== rtl/dhte_pkg.sv =====
// Shared constants, codes and helper functions for the hash table engine.
package dhte_pkg;

  localparam int CAP_W         = 11;
  localparam int KEY_W         = 64;
  localparam int VAL_W         = 64;
  localparam int ADV_W         = 31;
  localparam int HASH_W        = 64;
  localparam int DEPTH_DEFAULT = 1024;
  localparam int KEY_BITS_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd821;
  localparam logic [CAP_W-1:0] CAP_MIN   = 11'd7;
  localparam logic [31:0]      HASH_MULT = 32'd2654435761;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] TAG_FREE = 2'd0;
  localparam logic [1:0] TAG_LIVE = 2'd1;
  localparam logic [1:0] TAG_DEAD = 2'd2;

  localparam int NUM_PRIMES = 37;
  localparam logic [31:0] PRIME_LIST [NUM_PRIMES] = '{
    32'd7, 32'd13, 32'd29, 32'd59, 32'd113, 32'd223, 32'd431, 32'd821, 32'd1567,
    32'd2999, 32'd5701, 32'd10837, 32'd20593, 32'd39133, 32'd74353, 32'd141277,
    32'd268439, 32'd510047, 32'd969097, 32'd1841291, 32'd3498457, 32'd5247701,
    32'd7871573, 32'd11807381, 32'd17711087, 32'd26566649, 32'd39849977,
    32'd59774983, 32'd89662483, 32'd134493731, 32'd201740597, 32'd302610937,
    32'd453916423, 32'd680874641, 32'd1021311983, 32'd1531968019, 32'd2147483647
  };

  function automatic logic [31:0] next_prime_above(input logic [31:0] n);
    logic [31:0] res;
    logic        got;
    res = 32'd2147483647;
    got = 1'b0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (!got && PRIME_LIST[i] > n) begin
        res = PRIME_LIST[i];
        got = 1'b1;
      end
    end
    return res;
  endfunction

  // Resize advice from the capacity and the counts after an insert.
  function automatic logic [ADV_W-1:0] advise(input logic [CAP_W-1:0] c,
                                              input logic [CAP_W-1:0] live,
                                              input logic [CAP_W-1:0] used);
    logic [31:0] res;
    logic [31:0] grown;
    grown = 32'(live) + 32'(live >> 1) + 32'(live >> 2);
    if (used < c - (c >> 3)) begin
      res = 32'd0;
    end else if (live < c - (c >> 2)) begin
      if (live < (used >> 2)) begin
        res = next_prime_above(grown);
      end else begin
        res = 32'(c);
      end
    end else begin
      res = next_prime_above(32'(c));
    end
    return res[ADV_W-1:0];
  endfunction

endpackage

// ===== rtl/double_hash_table_engine_top.sv =====
// Top level of the double hash table engine: sequencer, shared units and slot stores.
//
// Open-addressed key/value table with double hashing. Pulse start with
// in_mode, in_key and in_value while busy is low; the item is taken at that
// edge and busy stays high until its result has been produced. Each item
// yields exactly one result, shown for a single cycle with out_strobe high;
// the receiver cannot stall it, so it must capture the result in that cycle.
// An item keeps busy high through these steps: the address hash (two passes of
// the shared 32x32 multiplier, then the final add), the one-bit-per-cycle
// remainder unit over the 64 hash bits for the home slot modulo capacity, the
// same unit over 11 more bits for the probe step, a registered memory read and
// then a compare for each slot probed, one update and one report. The result
// shows in the cycle busy falls, so the next item can be taken at the end of
// that cycle. Mode three skips the walk and goes straight to report. After
// reset and after every write of cfg_wr_data the slot tags of all TABLE_DEPTH
// entries are cleared one entry a cycle with busy high; writing capacity
// empties the table.
// Capacity is clamped to [7, TABLE_DEPTH] when used and should only be
// written while busy is low.
module double_hash_table_engine_top #(
  parameter int TABLE_DEPTH = dhte_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS    = dhte_pkg::KEY_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [dhte_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [dhte_pkg::KEY_W-1:0]  in_key,
  input  logic [dhte_pkg::VAL_W-1:0]  in_value,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic [dhte_pkg::VAL_W-1:0]  out_read_value,
  output logic                        out_status,
  output logic [dhte_pkg::ADV_W-1:0]  out_resize_advice,
  output logic [dhte_pkg::CAP_W-1:0]  out_live_entries,
  output logic [dhte_pkg::CAP_W-1:0]  out_used_entries
);
  import dhte_pkg::*;

  `include "double_hash_table_engine_top_assert.svh"

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(HASH_W + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MUL_LO, ST_MUL_HI, ST_MUL_ADD, ST_HOME_DIV,
    ST_STEP_DIV, ST_PROBE_RD, ST_PROBE_CHK, ST_UPDATE, ST_REPORT
  } state_t;

  state_t state_r;

  // Configuration and counts
  logic [CAP_W-1:0] cap_r, live_r, used_r;

  // Item registers
  logic [1:0]          mode_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VAL_W-1:0]    value_r;
  logic [CAP_W-1:0]    c_r, d_r;

  // Hash and shared remainder unit
  logic [63:0]       prod_r, acc_r, div_num_r;
  logic [CAP_W-1:0]  div_rem_r;
  logic [CNT_W-1:0]  div_cnt_r;

  // Walk state
  logic [CAP_W-1:0] home_r, step_r, idx_r, dead_r;
  logic             hit_r, saw_free_r, saw_dead_r, op_ok_r;
  logic [AW-1:0]    clr_r;

  // Slot stores, read data registered
  logic [1:0]          tag_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0]    val_mem [TABLE_DEPTH];
  logic [1:0]          tag_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]    val_q;

  // Result registers
  logic                out_strobe_r, out_found_r, out_status_r;
  logic [VAL_W-1:0]    out_rd_r;
  logic [ADV_W-1:0]    out_adv_r;
  logic [CAP_W-1:0]    out_live_r, out_used_r;

  // Combinational helpers
  logic               accept;
  logic [CAP_W-1:0]   c_eff, d_eff;
  logic [63:0]        key_ext;
  logic [31:0]        mul_a;
  logic [63:0]        prod;
  logic [CAP_W-1:0]   den;
  logic [CAP_W:0]     r2;
  logic [CAP_W-1:0]   rem_nxt;
  logic [CAP_W:0]     idx_sum;
  logic [CAP_W-1:0]   idx_nxt;
  logic               is_ins, ins_ok, del_hit;
  logic               tag_we, key_we, val_we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [1:0]         tag_wd;
  logic [VAL_W-1:0]   val_wd;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Effective capacity and second-hash distance
  always_comb begin
    c_eff = cap_r;
    if (cap_r < CAP_MIN) c_eff = CAP_MIN;
    if (32'(cap_r) > 32'(TABLE_DEPTH)) c_eff = CAP_W'(TABLE_DEPTH);
    d_eff = c_eff >> 6;
    if (d_eff < CAP_W'(8)) d_eff = (c_eff > CAP_W'(8)) ? CAP_W'(8) : CAP_W'(1);
  end

  // Shared multiplier: low then high half of (key >> 3)
  assign key_ext = 64'(key_r) >> 3;
  assign mul_a   = (state_r == ST_MUL_LO) ? key_ext[31:0] : key_ext[63:32];
  assign prod    = 64'(mul_a) * 64'(HASH_MULT);

  // Shared one-bit-per-cycle remainder unit
  assign den     = (state_r == ST_HOME_DIV) ? c_r : d_r;
  assign r2      = {div_rem_r, div_num_r[63]};
  assign rem_nxt = (r2 >= {1'b0, den}) ? CAP_W'(r2 - {1'b0, den}) : r2[CAP_W-1:0];

  // Probe advance with wrap
  assign idx_sum = {1'b0, idx_r} + {1'b0, step_r};
  assign idx_nxt = (idx_sum >= {1'b0, c_r}) ? CAP_W'(idx_sum - {1'b0, c_r})
                                            : idx_sum[CAP_W-1:0];

  // Write decisions
  assign is_ins  = (mode_r == MODE_INSERT);
  assign ins_ok  = is_ins && (hit_r || saw_dead_r || saw_free_r);
  assign del_hit = (mode_r == MODE_DELETE) && hit_r;

  always_comb begin
    tag_we  = 1'b0;
    key_we  = 1'b0;
    val_we  = 1'b0;
    tag_wd  = TAG_FREE;
    val_wd  = '0;
    wr_addr = AW'(idx_r);
    if (state_r == ST_CLEAR) begin
      tag_we  = 1'b1;
      wr_addr = clr_r;
    end else if (state_r == ST_UPDATE) begin
      if (ins_ok) begin
        tag_we = 1'b1;
        key_we = 1'b1;
        val_we = 1'b1;
        tag_wd = TAG_LIVE;
        val_wd = value_r;
        if (!hit_r && saw_dead_r) wr_addr = AW'(dead_r);
      end else if (del_hit) begin
        tag_we = 1'b1;
        val_we = 1'b1;
        tag_wd = TAG_DEAD;
      end
    end
  end

  assign rd_addr = AW'(idx_r);

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wd;
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_r;
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[wr_addr] <= val_wd;
    val_q <= val_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cap_r        <= CAP_RESET;
      live_r       <= '0;
      used_r       <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else if (cfg_wr_en) begin
      // A capacity write empties the table and restarts the clear sweep
      cap_r        <= cfg_wr_data;
      live_r       <= '0;
      used_r       <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
      state_r      <= ST_CLEAR;
    end else begin
      out_strobe_r <= (state_r == ST_REPORT);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r     <= in_mode;
            key_r      <= in_key[KEY_BITS-1:0];
            value_r    <= in_value;
            c_r        <= c_eff;
            d_r        <= d_eff;
            hit_r      <= 1'b0;
            saw_free_r <= 1'b0;
            saw_dead_r <= 1'b0;
            op_ok_r    <= 1'b0;
            out_status_r <= 1'b0;
            out_rd_r   <= '0;
            if (in_mode == MODE_LOOKUP || in_mode == MODE_INSERT ||
                in_mode == MODE_DELETE) begin
              state_r <= ST_MUL_LO;
            end else begin
              state_r <= ST_REPORT;
            end
          end
        end
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_SLOT) state_r <= ST_IDLE;
        end
        ST_MUL_LO: begin
          prod_r  <= prod;
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          acc_r   <= prod_r + 64'(key_r[2:0]);
          prod_r  <= prod;
          state_r <= ST_MUL_ADD;
        end
        ST_MUL_ADD: begin
          div_num_r <= acc_r + {prod_r[31:0], 32'h0};
          div_rem_r <= '0;
          div_cnt_r <= CNT_W'(HASH_W);
          state_r   <= ST_HOME_DIV;
        end
        ST_HOME_DIV: begin
          if (div_cnt_r == CNT_W'(1)) begin
            home_r    <= rem_nxt;
            div_num_r <= {rem_nxt, (HASH_W - CAP_W)'(0)};
            div_rem_r <= '0;
            div_cnt_r <= CNT_W'(CAP_W);
            state_r   <= ST_STEP_DIV;
          end else begin
            div_num_r <= div_num_r << 1;
            div_rem_r <= rem_nxt;
            div_cnt_r <= div_cnt_r - CNT_W'(1);
          end
        end
        ST_STEP_DIV: begin
          div_num_r <= div_num_r << 1;
          div_rem_r <= rem_nxt;
          div_cnt_r <= div_cnt_r - CNT_W'(1);
          if (div_cnt_r == CNT_W'(1)) begin
            step_r  <= d_r - rem_nxt;
            idx_r   <= home_r;
            state_r <= ST_PROBE_RD;
          end
        end
        ST_PROBE_RD: begin
          state_r <= ST_PROBE_CHK;
        end
        ST_PROBE_CHK: begin
          if (tag_q == TAG_FREE) begin
            saw_free_r <= 1'b1;
            state_r    <= ST_UPDATE;
          end else if (tag_q == TAG_LIVE && key_q == key_r) begin
            hit_r   <= 1'b1;
            state_r <= ST_UPDATE;
          end else begin
            if (tag_q != TAG_LIVE && !saw_dead_r) begin
              saw_dead_r <= 1'b1;
              dead_r     <= idx_r;
            end
            if (idx_nxt == home_r) begin
              state_r <= ST_UPDATE;
            end else begin
              idx_r   <= idx_nxt;
              state_r <= ST_PROBE_RD;
            end
          end
        end
        ST_UPDATE: begin
          if (mode_r == MODE_LOOKUP && hit_r) out_rd_r <= val_q;
          if (is_ins) begin
            op_ok_r      <= ins_ok;
            out_status_r <= !ins_ok;
            if (!hit_r && saw_dead_r) begin
              live_r <= live_r + CAP_W'(1);
            end else if (!hit_r && saw_free_r) begin
              live_r <= live_r + CAP_W'(1);
              used_r <= used_r + CAP_W'(1);
            end
          end else if (del_hit && live_r != '0) begin
            live_r <= live_r - CAP_W'(1);
          end
          state_r <= ST_REPORT;
        end
        ST_REPORT: begin
          out_found_r  <= hit_r;
          out_adv_r    <= op_ok_r ? advise(c_r, live_r, used_r) : '0;
          out_live_r   <= live_r;
          out_used_r   <= used_r;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_found         = out_found_r;
  assign out_read_value    = out_rd_r;
  assign out_status        = out_status_r;
  assign out_resize_advice = out_adv_r;
  assign out_live_entries  = out_live_r;
  assign out_used_entries  = out_used_r;

  // Checks
  `DHTE_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept && !cfg_wr_en, busy)
  `DHTE_ASSERT_NOW(a_counts_order, clk, rst_n, 1'b1, used_r >= live_r)
  `DHTE_ASSERT_NOW(a_full_no_advice, clk, rst_n, out_strobe_r && out_status_r,
                   out_adv_r == '0 && !out_found_r)
  `DHTE_ASSERT_NEXT(a_report_strobe, clk, rst_n, state_r == ST_REPORT && !cfg_wr_en,
                    out_strobe_r && !busy)

endmodule

// ===== test/double_hash_table_engine_top_tb.sv =====
// Self-checking testbench for the double hash table engine: random and directed table operations.
module double_hash_table_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dhte_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;  // above the worst item and a full clear pass
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             status;
    logic [ADV_W-1:0] advice;
    logic [CAP_W-1:0] live;
    logic [CAP_W-1:0] used;
  } table_answer_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_mode = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_strobe;
  logic             out_found;
  logic [VAL_W-1:0] out_read_value;
  logic             out_status;
  logic [ADV_W-1:0] out_resize_advice;
  logic [CAP_W-1:0] out_live_entries;
  logic [CAP_W-1:0] out_used_entries;

  double_hash_table_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_value(in_value),
    .out_strobe(out_strobe), .out_found(out_found), .out_read_value(out_read_value),
    .out_status(out_status), .out_resize_advice(out_resize_advice),
    .out_live_entries(out_live_entries), .out_used_entries(out_used_entries)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow table: our own copy of the slot store, counts and capacity
  // ---------------------------------------------------------------------------
  logic [1:0]       shadow_tag [DEPTH];
  logic [KEY_W-1:0] shadow_key [DEPTH];
  logic [VAL_W-1:0] shadow_val [DEPTH];
  int unsigned      shadow_live, shadow_used;
  logic [CAP_W-1:0] shadow_cap;

  table_op_t     pending_ops [$];   // items still to be driven
  table_answer_t awaited [$];       // answers predicted, not yet seen

  int mismatches = 0;
  int watchdog = 0;
  int quiet = 0;
  logic took = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  // Capacity write empties the table
  task automatic shadow_set_capacity(input logic [CAP_W-1:0] cap);
    shadow_cap = cap;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_tag[i] = TAG_FREE;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    shadow_live = 0;
    shadow_used = 0;
  endtask

  function automatic int unsigned prime_after(input int unsigned n);
    for (int i = 0; i < NUM_PRIMES; i++)
      if (PRIME_LIST[i] > n) return PRIME_LIST[i];
    return 32'd2147483647;
  endfunction

  function automatic int unsigned resize_hint(input int unsigned c);
    if (shadow_used < c - (c >> 3)) return 0;
    if (shadow_live < c - (c >> 2)) begin
      if (shadow_live < (shadow_used >> 2))
        return prime_after(shadow_live + (shadow_live >> 1) + (shadow_live >> 2));
      return c;
    end
    return prime_after(c);
  endfunction

  // Walk the probe sequence and apply one operation to the shadow table
  task automatic table_apply(input table_op_t op, output table_answer_t ans);
    int unsigned c, home, step, d, idx, hit_idx, dead_idx, free_idx, w;
    logic [63:0] h;
    bit hit, saw_dead, saw_free;
    c = shadow_cap;
    if (c < 7) c = 7;
    if (c > DEPTH) c = DEPTH;
    h = (op.key >> 3) * 64'd2654435761 + (op.key & 64'd7);
    home = h % c;
    d = c >> 6;
    if (d < 8) d = (c > 8) ? 8 : 1;
    step = d - (home % d);
    hit = 0; saw_dead = 0; saw_free = 0;
    hit_idx = 0; dead_idx = 0; free_idx = 0;
    ans = '0;
    if (op.mode != MODE_NOP) begin
      idx = home;
      do begin
        if (shadow_tag[idx] == TAG_FREE) begin
          saw_free = 1; free_idx = idx; break;
        end
        if (shadow_tag[idx] == TAG_LIVE) begin
          if (shadow_key[idx] == op.key) begin
            hit = 1; hit_idx = idx; break;
          end
        end else if (!saw_dead) begin
          saw_dead = 1; dead_idx = idx;
        end
        idx += step;
        if (idx >= c) idx -= c;
      end while (idx != home);
      ans.found = hit;
    end
    case (op.mode)
      MODE_LOOKUP: if (hit) ans.read_value = shadow_val[hit_idx];
      MODE_INSERT: begin
        if (hit || saw_dead || saw_free) begin
          if (hit) w = hit_idx;
          else if (saw_dead) begin
            w = dead_idx; shadow_live++;
          end else begin
            w = free_idx; shadow_live++; shadow_used++;
          end
          shadow_tag[w] = TAG_LIVE;
          shadow_key[w] = op.key;
          shadow_val[w] = op.value;
          ans.advice = ADV_W'(resize_hint(c));
        end else begin
          ans.status = 1'b1;   // whole cycle probed, no room
        end
      end
      MODE_DELETE: if (hit) begin
        shadow_tag[hit_idx] = TAG_DEAD;
        shadow_val[hit_idx] = '0;
        if (shadow_live > 0) shadow_live--;
      end
      default: ;
    endcase
    ans.live = CAP_W'(shadow_live);
    ans.used = CAP_W'(shadow_used);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item at a time, bursts with random gaps, inputs move on negedge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic next_start;
    logic next_cfg_en;
    next_start = start;
    next_cfg_en = 1'b0;
    if (rst_n) begin
      if (start && took) next_start = 1'b0;
      if (!next_start && pending_ops.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops[0].is_cfg) begin
          // only once the engine is quiet and all answers are in
          if (quiet >= 16) begin
            next_cfg_en = 1'b1;
            cfg_wr_data <= pending_ops[0].cap;
            shadow_set_capacity(pending_ops[0].cap);
            void'(pending_ops.pop_front());
          end
        end else begin
          next_start = 1'b1;
          in_mode  <= pending_ops[0].mode;
          in_key   <= pending_ops[0].key;
          in_value <= pending_ops[0].value;
          void'(pending_ops.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            // a fair share of bursts run with no gap at all
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      start <= next_start;
      cfg_wr_en <= next_cfg_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check answers, predict accepted items, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_answer_t want, got;
    table_op_t op;
    if (!rst_n) begin
      took <= 1'b0;
      quiet <= 0;
    end else begin
      if (out_strobe) begin
        got = '{out_found, out_read_value, out_status, out_resize_advice,
                out_live_entries, out_used_entries};
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected answer: %p", got);
        end else begin
          want = awaited.pop_front();
          if (got.found != want.found || got.read_value != want.read_value ||
              got.status != want.status || got.advice != want.advice ||
              got.live != want.live || got.used != want.used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("answer mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        op = '{1'b0, '0, in_mode, in_key, in_value};
        table_apply(op, want);
        awaited.push_back(want);
      end
      quiet <= (awaited.size() == 0 && !busy && !start && !cfg_wr_en) ? quiet + 1 : 0;
      if ((start && !busy) || out_strobe || cfg_wr_en) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_op(input logic [1:0] mode, input logic [63:0] key,
                        input logic [63:0] value);
    pending_ops.push_back('{1'b0, '0, mode, key, value});
  endtask

  task automatic add_cap(input logic [CAP_W-1:0] cap);
    pending_ops.push_back('{1'b1, cap, 2'd0, 64'd0, 64'd0});
  endtask

  // Random traffic over a key pool of four keys more than the slots for tables up to 64 slots,
  // 40 keys otherwise, so that hits, churn, tombstones and full tables all show up
  task automatic random_phase(input logic [CAP_W-1:0] cap, input int count);
    logic [63:0] pool [$];
    logic [63:0] k;
    int eff, pool_size, pick;
    logic [1:0] m;
    eff = (cap < 7) ? 7 : (cap > DEPTH) ? DEPTH : cap;
    pool_size = (eff <= 64) ? eff + 4 : 40;
    for (int i = 0; i < pool_size; i++) pool.push_back(rand64());
    pool[0] = '0;
    pool[1] = '1;
    add_cap(cap);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) m = MODE_INSERT;
      else if (pick < 65) m = MODE_LOOKUP;
      else if (pick < 94) m = MODE_DELETE;
      else m = MODE_NOP;
      k = ($urandom_range(0, 9) == 0) ? rand64() : pool[$urandom_range(0, pool_size - 1)];
      add_op(m, k, rand64());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [9];
    caps = '{11'd2047, 11'd13, 11'd8, 11'd1024, 11'd29,
             11'd7, 11'd821, 11'd1, 11'd59};
    // directed, reset capacity
    add_op(MODE_LOOKUP, 64'd0, 64'd5);
    add_op(MODE_INSERT, 64'd0, 64'd0);
    add_op(MODE_INSERT, '1, '1);
    add_op(MODE_LOOKUP, '1, 64'd0);
    add_op(MODE_INSERT, '1, 64'h5a5a_5a5a_a5a5_a5a5);  // overwrite
    add_op(MODE_LOOKUP, '1, 64'd0);
    add_op(MODE_DELETE, 64'd0, 64'd0);
    add_op(MODE_DELETE, 64'd0, 64'd0);                  // missing key
    add_op(MODE_LOOKUP, 64'd0, 64'd0);
    add_op(MODE_NOP, '1, '1);
    add_op(MODE_INSERT, 64'd0, 64'h1234);               // back into the tombstone
    // capacity below range clamps to seven slots: fill, overflow, churn
    add_cap(11'd0);
    for (int i = 0; i < 8; i++) add_op(MODE_INSERT, 64'(i * 9 + 1), rand64());
    add_op(MODE_DELETE, 64'd1, 64'd0);
    add_op(MODE_DELETE, 64'd10, 64'd0);
    add_op(MODE_INSERT, 64'd64, 64'd7);                 // new key lands on a tombstone
    add_op(MODE_INSERT, 64'd19, 64'd8);                 // present key past a tombstone
    add_op(MODE_LOOKUP, 64'd19, 64'd0);
    for (int p = 0; p < 9; p++) random_phase(caps[p], 48);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    wait (pending_ops.size() == 0 && !start);
    wait (awaited.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
